### rtl/p2fl_pkg.sv
// Shared types, constants and the microcode program of the power-of-two free-list allocator.
`default_nettype none

package p2fl_pkg;

    // Default geometry
    localparam int ADDR_BITS_DEF     = 24;
    localparam int TOP_LEVEL_DEF     = 19;
    localparam int GRANULE_LEVEL_DEF = 12;

    // Fixed port widths
    localparam int LEVEL_W         = 5;
    localparam int ADDR_W          = 24;
    localparam int CFG_W           = 5;
    localparam int CHUNK_LIMIT_RST = 16;

    // Microcode address width
    localparam int UPC_W = 5;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_OOM   = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_LINK_FREE,
        OP_POP_ISSUE,
        OP_POP_LOAD,
        OP_CARVE,
        OP_CUR_INC,
        OP_CUR_DEC,
        OP_SPLIT,
        OP_RESP
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_START,
        C_BAD_LEVEL,
        C_IS_FREE,
        C_HEAD_VALID,
        C_CUR_TOP,
        C_CHUNK_OUT,
        C_CUR_AT_LV
    } cond_t;

    typedef struct packed {
        op_t     op;
        cond_t   cond;
        upc_t    target;
        status_t status;
        logic    use_blk;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic bad_level;
        logic is_free;
        logic head_valid;
        logic cur_top;
        logic chunk_out;
        logic cur_at_lv;
    } flags_t;

    // Program step addresses
    localparam upc_t S_IDLE       = 5'd0;
    localparam upc_t S_CHECK      = 5'd1;
    localparam upc_t S_KIND       = 5'd2;
    localparam upc_t S_SCAN       = 5'd3;
    localparam upc_t S_TOP        = 5'd4;
    localparam upc_t S_NEXT_LV    = 5'd5;
    localparam upc_t S_POP        = 5'd6;
    localparam upc_t S_POP_LD     = 5'd7;
    localparam upc_t S_CARVE_CHK  = 5'd8;
    localparam upc_t S_CARVE      = 5'd9;
    localparam upc_t S_SPLIT_CHK  = 5'd10;
    localparam upc_t S_SPLIT_DEC  = 5'd11;
    localparam upc_t S_SPLIT      = 5'd12;
    localparam upc_t S_RESP_BLK   = 5'd13;
    localparam upc_t S_RESP_OOM   = 5'd14;
    localparam upc_t S_RESP_RANGE = 5'd15;
    localparam upc_t S_FREE       = 5'd16;
    localparam upc_t S_RESP_FREE  = 5'd17;

    // Control store: a jump is taken when its condition holds, else fall through
    function automatic ctrl_t ucode(input upc_t a);
        ctrl_t w;
        begin
            case (a)
                S_IDLE:       w = '{OP_LATCH,     C_NO_START,   S_IDLE,       STATUS_OK,    1'b0};
                S_CHECK:      w = '{OP_NOP,       C_BAD_LEVEL,  S_RESP_RANGE, STATUS_OK,    1'b0};
                S_KIND:       w = '{OP_NOP,       C_IS_FREE,    S_FREE,       STATUS_OK,    1'b0};
                S_SCAN:       w = '{OP_NOP,       C_HEAD_VALID, S_POP,        STATUS_OK,    1'b0};
                S_TOP:        w = '{OP_NOP,       C_CUR_TOP,    S_CARVE_CHK,  STATUS_OK,    1'b0};
                S_NEXT_LV:    w = '{OP_CUR_INC,   C_ALWAYS,     S_SCAN,       STATUS_OK,    1'b0};
                S_POP:        w = '{OP_POP_ISSUE, C_ALWAYS,     S_POP_LD,     STATUS_OK,    1'b0};
                S_POP_LD:     w = '{OP_POP_LOAD,  C_ALWAYS,     S_SPLIT_CHK,  STATUS_OK,    1'b0};
                S_CARVE_CHK:  w = '{OP_NOP,       C_CHUNK_OUT,  S_RESP_OOM,   STATUS_OK,    1'b0};
                S_CARVE:      w = '{OP_CARVE,     C_ALWAYS,     S_SPLIT_CHK,  STATUS_OK,    1'b0};
                S_SPLIT_CHK:  w = '{OP_NOP,       C_CUR_AT_LV,  S_RESP_BLK,   STATUS_OK,    1'b0};
                S_SPLIT_DEC:  w = '{OP_CUR_DEC,   C_ALWAYS,     S_SPLIT,      STATUS_OK,    1'b0};
                S_SPLIT:      w = '{OP_SPLIT,     C_ALWAYS,     S_SPLIT_CHK,  STATUS_OK,    1'b0};
                S_RESP_BLK:   w = '{OP_RESP,      C_ALWAYS,     S_IDLE,       STATUS_OK,    1'b1};
                S_RESP_OOM:   w = '{OP_RESP,      C_ALWAYS,     S_IDLE,       STATUS_OOM,   1'b0};
                S_RESP_RANGE: w = '{OP_RESP,      C_ALWAYS,     S_IDLE,       STATUS_RANGE, 1'b0};
                S_FREE:       w = '{OP_LINK_FREE, C_ALWAYS,     S_RESP_FREE,  STATUS_OK,    1'b0};
                S_RESP_FREE:  w = '{OP_RESP,      C_ALWAYS,     S_IDLE,       STATUS_OK,    1'b0};
                default:      w = '{OP_NOP,       C_ALWAYS,     S_IDLE,       STATUS_OK,    1'b0};
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/p2fl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module p2fl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/p2fl_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module p2fl_seq
    import p2fl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire flags_t flags,
    output ctrl_t       ctrl,
    output logic        busy
);

    upc_t upc_reg;
    upc_t upc_next;
    logic take;

    assign ctrl = ucode(upc_reg);
    assign busy = (upc_reg != S_IDLE);

    // Condition select
    always_comb
    begin
        case (ctrl.cond)
            C_ALWAYS:     take = 1'b1;
            C_NO_START:   take = !flags.start;
            C_BAD_LEVEL:  take = flags.bad_level;
            C_IS_FREE:    take = flags.is_free;
            C_HEAD_VALID: take = flags.head_valid;
            C_CUR_TOP:    take = flags.cur_top;
            C_CHUNK_OUT:  take = flags.chunk_out;
            C_CUR_AT_LV:  take = flags.cur_at_lv;
            default:      take = 1'b1;
        endcase
        upc_next = take ? ctrl.target : upc_t'(upc_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

### rtl/p2fl_dp.sv
// Allocator datapath: list heads, level cursor, block register, chunk counter and link store.
`default_nettype none

module p2fl_dp
    import p2fl_pkg::*;
#(
    parameter int ADDR_BITS     = ADDR_BITS_DEF,
    parameter int TOP_LEVEL     = TOP_LEVEL_DEF,
    parameter int GRANULE_LEVEL = GRANULE_LEVEL_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctrl_t              ctrl,
    input  wire logic               start,
    input  wire logic               kind,
    input  wire logic [LEVEL_W-1:0] level,
    input  wire logic [ADDR_W-1:0]  address,
    input  wire logic               cfg_valid,
    input  wire logic [CFG_W-1:0]   cfg_data,
    output logic                    cfg_ready,
    output flags_t                  flags,
    output logic                    done,
    output logic [ADDR_W-1:0]       block_address,
    output logic [1:0]              status
);

    localparam int NLEVELS  = TOP_LEVEL - GRANULE_LEVEL + 1;
    localparam int IDX_W    = ADDR_BITS - GRANULE_LEVEL;
    localparam int HEAD_W   = IDX_W + 1;
    localparam int NGRAN    = 1 << IDX_W;
    localparam int LVL_W    = $clog2(NLEVELS + 1);
    localparam int LI_W     = (NLEVELS > 1) ? $clog2(NLEVELS) : 1;
    localparam int CHUNK_SH = TOP_LEVEL + 1 - GRANULE_LEVEL;
    localparam int FIT_DIFF = ADDR_BITS - (TOP_LEVEL + 1);
    localparam int CHUNK_FIT = (FIT_DIFF < 0) ? 0 : ((FIT_DIFF >= 5) ? 31 : (1 << FIT_DIFF));
    localparam logic [HEAD_W-1:0] NIL = {1'b1, {IDX_W{1'b0}}};

    logic [HEAD_W-1:0] heads_reg [NLEVELS];
    logic [HEAD_W-1:0] heads_next [NLEVELS];
    logic              kind_reg, kind_next;
    logic              bad_reg, bad_next;
    logic [LVL_W-1:0]  lv_reg, lv_next;
    logic [LVL_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  blk_reg, blk_next;
    logic [4:0]        chunks_used_reg, chunks_used_next;
    logic [CFG_W-1:0]  chunk_limit_reg, chunk_limit_next;
    logic              done_reg, done_next;
    logic [ADDR_W-1:0] block_address_reg, block_address_next;
    status_t           status_reg, status_next;

    logic [LI_W-1:0]      cur_idx;
    logic [HEAD_W-1:0]    head_cur;
    logic [LEVEL_W-1:0]   level_off;
    logic [ADDR_BITS-1:0] blk_byte;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [HEAD_W-1:0]    ram_wdata;
    logic [HEAD_W-1:0]    ram_rdata;

    assign cur_idx   = cur_reg[LI_W-1:0];
    assign head_cur  = heads_reg[cur_idx];
    assign level_off = level - LEVEL_W'(GRANULE_LEVEL);
    assign blk_byte  = {blk_reg, {GRANULE_LEVEL{1'b0}}};
    assign cfg_ready = 1'b1;

    // Link store: one entry per granule
    p2fl_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (NGRAN)
    ) u_link (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_cur[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Status to the sequencer
    always_comb
    begin
        flags.start      = start;
        flags.bad_level  = bad_reg;
        flags.is_free    = kind_reg;
        flags.head_valid = !head_cur[IDX_W];
        flags.cur_top    = (cur_reg == LVL_W'(NLEVELS - 1));
        flags.chunk_out  = (chunks_used_reg >= chunk_limit_reg) ||
                           (chunks_used_reg >= 5'(CHUNK_FIT));
        flags.cur_at_lv  = (cur_reg == lv_reg);
    end

    // Operation decode
    always_comb
    begin
        heads_next         = heads_reg;
        kind_next          = kind_reg;
        bad_next           = bad_reg;
        lv_next            = lv_reg;
        cur_next           = cur_reg;
        blk_next           = blk_reg;
        chunks_used_next   = chunks_used_reg;
        chunk_limit_next   = chunk_limit_reg;
        done_next          = 1'b0;
        block_address_next = block_address_reg;
        status_next        = status_reg;
        ram_we             = 1'b0;
        ram_waddr          = blk_reg;
        ram_wdata          = head_cur;

        if (cfg_valid)
        begin
            chunk_limit_next = cfg_data;
        end

        case (ctrl.op)
            OP_LATCH:
            begin
                kind_next = kind;
                bad_next  = (level < LEVEL_W'(GRANULE_LEVEL)) || (level > LEVEL_W'(TOP_LEVEL));
                lv_next   = LVL_W'(level_off);
                cur_next  = LVL_W'(level_off);
                blk_next  = IDX_W'(address >> GRANULE_LEVEL);
            end
            OP_LINK_FREE, OP_SPLIT:
            begin
                // push the block on the cursor's list
                ram_we             = 1'b1;
                heads_next[cur_idx] = {1'b0, blk_reg};
                if (ctrl.op == OP_SPLIT)
                begin
                    blk_next = blk_reg + (IDX_W'(1) << cur_reg);
                end
            end
            OP_POP_ISSUE:
            begin
                blk_next = head_cur[IDX_W-1:0];
            end
            OP_POP_LOAD:
            begin
                heads_next[cur_idx] = ram_rdata;
            end
            OP_CARVE:
            begin
                blk_next         = IDX_W'(IDX_W'(chunks_used_reg) << CHUNK_SH);
                chunks_used_next = chunks_used_reg + 5'd1;
                cur_next         = LVL_W'(NLEVELS);
            end
            OP_CUR_INC:
            begin
                cur_next = cur_reg + LVL_W'(1);
            end
            OP_CUR_DEC:
            begin
                cur_next = cur_reg - LVL_W'(1);
            end
            OP_RESP:
            begin
                done_next          = 1'b1;
                status_next        = ctrl.status;
                block_address_next = ctrl.use_blk ? ADDR_W'(blk_byte) : '0;
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NLEVELS; i++)
            begin
                heads_reg[i] <= NIL;
            end
            chunks_used_reg <= '0;
            chunk_limit_reg <= CFG_W'(CHUNK_LIMIT_RST);
            done_reg        <= 1'b0;
        end
        else
        begin
            heads_reg       <= heads_next;
            chunks_used_reg <= chunks_used_next;
            chunk_limit_reg <= chunk_limit_next;
            done_reg        <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg          <= kind_next;
        bad_reg           <= bad_next;
        lv_reg            <= lv_next;
        cur_reg           <= cur_next;
        blk_reg           <= blk_next;
        block_address_reg <= block_address_next;
        status_reg        <= status_next;
    end

    assign done          = done_reg;
    assign block_address = block_address_reg;
    assign status        = status_reg;

endmodule

`default_nettype wire

### rtl/pow2_free_list_allocator_top.sv
// Top level of the segregated power-of-two free-list allocator.
//
// Usage: a request is taken at a clock edge with start high and busy low;
// kind selects allocate (0) or free (1), level is log2 of the block size and
// address is the block freed. One result per request appears on
// block_address and status, marked by done, which is high for a single
// cycle; the receiver cannot stall it. chunk_limit is written through
// cfg_valid / cfg_data (cfg_ready is always high); the user must write it
// only while the block is idle; the block itself does not enforce this.
// Timing: a microcoded sequencer steps through a small control store, one
// step per cycle; the list heads sit in flip-flops and the link store is a
// single RAM with registered read. A free pushes the block on the list of
// its level. An allocate pops its own list if that is non-empty, else it
// climbs to the first non-empty list above, pops it and splits back down;
// with every list empty it carves a fresh chunk at the top and splits it.
// A bad level gets a range status, a carve past chunk_limit or the pool
// size gets out of memory. One request at a time.
// Reset: all lists empty, no chunks used, chunk_limit 16; the link store
// needs no clearing, as every entry is written before it is read.
`default_nettype none

module pow2_free_list_allocator_top
    import p2fl_pkg::*;
#(
    parameter int ADDR_BITS     = ADDR_BITS_DEF,
    parameter int TOP_LEVEL     = TOP_LEVEL_DEF,
    parameter int GRANULE_LEVEL = GRANULE_LEVEL_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               kind,
    input  wire logic [LEVEL_W-1:0] level,
    input  wire logic [ADDR_W-1:0]  address,
    output logic                    done,
    output logic [ADDR_W-1:0]       block_address,
    output logic [1:0]              status,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CFG_W-1:0]   cfg_data
);

    ctrl_t  ctrl;
    flags_t flags;

    // Sequencer
    p2fl_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // Datapath
    p2fl_dp #(
        .ADDR_BITS     (ADDR_BITS),
        .TOP_LEVEL     (TOP_LEVEL),
        .GRANULE_LEVEL (GRANULE_LEVEL)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .start         (start),
        .kind          (kind),
        .level         (level),
        .address       (address),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .cfg_ready     (cfg_ready),
        .flags         (flags),
        .done          (done),
        .block_address (block_address),
        .status        (status)
    );

endmodule

`default_nettype wire

### test/pow2_free_list_allocator_top_tb.sv
// Self-checking testbench for the power-of-two free-list allocator top level.
`default_nettype none

module pow2_free_list_allocator_top_tb;
    import p2fl_pkg::*;

    // Geometry of the block under test
    localparam int AB         = ADDR_BITS_DEF;
    localparam int TL         = TOP_LEVEL_DEF;
    localparam int GL         = GRANULE_LEVEL_DEF;
    localparam int NUM_LEVELS = TL - GL + 1;
    localparam int IDX_W      = AB - GL;
    localparam int NUM_GRAN   = 1 << IDX_W;
    localparam int POOL_DIFF  = AB - (TL + 1);
    localparam int POOL_CHUNKS = (POOL_DIFF < 0) ? 0 : (POOL_DIFF >= 5) ? 31 : (1 << POOL_DIFF);

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [LEVEL_W-1:0] LVL_GRAN = LEVEL_W'(GL);
    localparam logic [LEVEL_W-1:0] LVL_TOP  = LEVEL_W'(TL);
    localparam logic [LEVEL_W-1:0] LVL_MAX  = LEVEL_W'(2 ** LEVEL_W - 1);
    localparam logic [ADDR_W-1:0]  ADDR_MAX = '1;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_TAIL  = 64;

    typedef struct packed {
        logic [ADDR_W-1:0] blk_addr;
        status_t           stat;
    } alloc_result_t;

    typedef struct {
        logic [ADDR_W-1:0]  base;
        logic [LEVEL_W-1:0] lvl;
    } live_block_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                kind = 1'b0;
    logic [LEVEL_W-1:0]  level = '0;
    logic [ADDR_W-1:0]   address = '0;
    logic                cfg_valid = 1'b0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                busy;
    logic                done;
    logic [ADDR_W-1:0]   block_address;
    logic [1:0]          status;
    logic                cfg_ready;

    // Predictor state
    logic [IDX_W:0]      list_head [NUM_LEVELS];
    logic [IDX_W:0]      link_mem [NUM_GRAN];
    logic [CFG_W-1:0]    carved_chunks;
    logic [CFG_W-1:0]    carve_limit;

    alloc_result_t       expected_results [$];
    live_block_t         live_blocks [$];
    int                  fail_count = 0;
    bit                  sender_idle = 1'b1;

    pow2_free_list_allocator_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .level         (level),
        .address       (address),
        .done          (done),
        .block_address (block_address),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // Allocator behaviour: one response per request, state updated in place
    function automatic alloc_result_t predict_response(input logic k,
                                                       input logic [LEVEL_W-1:0] lvl,
                                                       input logic [ADDR_W-1:0] addr);
        alloc_result_t r;
        int lv;
        int hit;
        int j;
        logic [IDX_W-1:0] blk;
        r.blk_addr = '0;
        r.stat = STATUS_OK;
        if (lvl < LVL_GRAN || lvl > LVL_TOP) begin
            r.stat = STATUS_RANGE;
            return r;
        end
        lv = int'(lvl) - GL;

        // free: push granule unchecked
        if (k == KIND_FREE) begin
            blk = addr[AB-1:GL];
            link_mem[blk] = list_head[lv];
            list_head[lv] = {1'b0, blk};
            return r;
        end

        // own list hit
        if (!list_head[lv][IDX_W]) begin
            blk = list_head[lv][IDX_W-1:0];
            list_head[lv] = link_mem[blk];
            r.blk_addr = ADDR_W'(blk) << GL;
            return r;
        end

        // search upwards, else carve a fresh chunk
        hit = -1;
        for (j = lv + 1; j < NUM_LEVELS; j++)
            if (hit < 0 && !list_head[j][IDX_W])
                hit = j;
        if (hit >= 0) begin
            blk = list_head[hit][IDX_W-1:0];
            list_head[hit] = link_mem[blk];
        end else begin
            if (carved_chunks >= carve_limit || int'(carved_chunks) >= POOL_CHUNKS) begin
                r.stat = STATUS_OOM;
                return r;
            end
            blk = IDX_W'(int'(carved_chunks) << (TL + 1 - GL));
            carved_chunks = carved_chunks + 1'b1;
            hit = NUM_LEVELS;
        end

        // split down; lower half goes on the list, upper half carries on
        while (hit > lv) begin
            hit--;
            link_mem[blk] = list_head[hit];
            list_head[hit] = {1'b0, blk};
            blk = blk + IDX_W'(1 << hit);
        end
        r.blk_addr = ADDR_W'(blk) << GL;
        return r;
    endfunction

    // Mostly small levels, now and then anything up to the top
    function automatic logic [LEVEL_W-1:0] pick_level();
        if ($urandom_range(0, 9) < 6)
            return LEVEL_W'($urandom_range(GL, GL + 2));
        return LEVEL_W'($urandom_range(GL, TL));
    endfunction

    // Send one request beat; called and returning just after a falling edge
    task automatic issue_request(input logic k, input logic [LEVEL_W-1:0] lvl,
                                 input logic [ADDR_W-1:0] addr);
        alloc_result_t exp_r;
        start   <= 1'b1;
        kind    <= k;
        level   <= lvl;
        address <= addr;
        do
            @(posedge clk);
        while (busy);
        exp_r = predict_response(k, lvl, addr);
        expected_results.push_back(exp_r);
        if (k == KIND_ALLOC && exp_r.stat == STATUS_OK)
            live_blocks.push_back('{exp_r.blk_addr, lvl});
        @(negedge clk);
        // random idle burst with junk on the fields
        if (sender_idle && $urandom_range(0, 3) == 0) begin
            start   <= 1'b0;
            kind    <= 1'($urandom_range(0, 1));
            level   <= LEVEL_W'($urandom);
            address <= ADDR_W'($urandom);
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    // Register write, only once the block has gone quiet
    task automatic write_chunk_limit(input logic [CFG_W-1:0] value);
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0 || busy);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        carve_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= CFG_W'($urandom);
    endtask

    // Levels outside granule..top, both kinds
    task automatic test_level_range();
        issue_request(KIND_ALLOC, '0, '0);
        issue_request(KIND_FREE, LVL_GRAN - 1'b1, ADDR_MAX);
        issue_request(KIND_ALLOC, LVL_TOP + 1'b1, ADDR_MAX);
        issue_request(KIND_FREE, LVL_MAX, '0);
        issue_request(KIND_FREE, '0, ADDR_MAX);
        issue_request(KIND_ALLOC, LVL_MAX, '0);
    endtask

    // No chunks allowed: out of memory unless a freed block is on hand
    task automatic test_no_chunks();
        write_chunk_limit('0);
        issue_request(KIND_ALLOC, LVL_GRAN, '0);
        issue_request(KIND_ALLOC, LVL_TOP, ADDR_MAX);
        issue_request(KIND_FREE, LVL_GRAN, ADDR_MAX);
        issue_request(KIND_ALLOC, LVL_GRAN, '0);
        issue_request(KIND_ALLOC, LVL_GRAN, '0);
    endtask

    // Carve, split all the way down, scan upwards, run out of chunks
    task automatic test_carve_and_split();
        write_chunk_limit(CFG_W'(2));
        issue_request(KIND_ALLOC, LVL_GRAN, '0);
        issue_request(KIND_ALLOC, LVL_GRAN, '0);
        issue_request(KIND_ALLOC, LVL_TOP, '0);
        issue_request(KIND_ALLOC, LVL_TOP, '0);
        issue_request(KIND_ALLOC, LVL_TOP, '0);
        issue_request(KIND_ALLOC, LVL_TOP, '0);
        issue_request(KIND_ALLOC, LVL_GRAN + 1'b1, '0);
    endtask

    // Double free and a foreign block near the top of the address space
    task automatic test_double_free();
        issue_request(KIND_FREE, LVL_GRAN + 2'd2, ADDR_W'(24'h004000));
        issue_request(KIND_FREE, LVL_GRAN + 2'd2, ADDR_W'(24'h004000));
        issue_request(KIND_ALLOC, LVL_GRAN + 2'd2, '0);
        issue_request(KIND_ALLOC, LVL_GRAN + 2'd2, '0);
        issue_request(KIND_FREE, LVL_TOP, ADDR_W'(24'hFFF000));
        issue_request(KIND_ALLOC, LVL_GRAN, '0);
    endtask

    // Mixed traffic: mostly allocate and free of live blocks, some noise
    task automatic test_random_traffic(input int n_items, input logic [CFG_W-1:0] limit,
                                       input bit with_idle);
        int r;
        int pick;
        logic k;
        logic [LEVEL_W-1:0] lvl;
        logic [ADDR_W-1:0] addr;
        live_block_t b;
        write_chunk_limit(limit);
        sender_idle = with_idle;
        repeat (n_items) begin
            r    = $urandom_range(0, 99);
            k    = KIND_ALLOC;
            lvl  = pick_level();
            addr = ADDR_W'($urandom);
            if (r >= 45 && r < 85 && live_blocks.size() != 0) begin
                pick = $urandom_range(0, live_blocks.size() - 1);
                b = live_blocks[pick];
                live_blocks.delete(pick);
                k    = KIND_FREE;
                addr = b.base;
                lvl  = b.lvl;
                if ($urandom_range(0, 7) == 0)
                    addr = addr | ADDR_W'($urandom_range(0, (1 << GL) - 1));
                if ($urandom_range(0, 15) == 0)
                    lvl = pick_level();
            end else if (r >= 85 && r < 93) begin
                k   = 1'($urandom_range(0, 1));
                lvl = $urandom_range(0, 1) ? LEVEL_W'($urandom_range(0, GL - 1))
                                           : LEVEL_W'($urandom_range(TL + 1, 2 ** LEVEL_W - 1));
            end else if (r >= 93) begin
                k = KIND_FREE;
            end
            issue_request(k, lvl, addr);
        end
    endtask

    // Result checker: every done beat against the oldest expectation
    always @(posedge clk) begin : check_results
        alloc_result_t exp_r;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: block_address %h status %0d", block_address, status);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (block_address !== exp_r.blk_addr) begin
                    $error("block_address: expected %h, actual %h", exp_r.blk_addr, block_address);
                    fail_count++;
                end
                if (status !== exp_r.stat) begin
                    $error("status: expected %0d, actual %0d", exp_r.stat, status);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat of any kind
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("pow2_free_list_allocator_top_tb: errors");
        $finish;
    end

    // Main sequence
    initial begin : main_seq
        int i;
        for (i = 0; i < NUM_LEVELS; i++)
            list_head[i] = {1'b1, {IDX_W{1'b0}}};
        carved_chunks = '0;
        carve_limit   = CFG_W'(CHUNK_LIMIT_RST);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_level_range();
        test_no_chunks();
        test_carve_and_split();
        test_double_free();
        test_random_traffic(500, CFG_W'(4), 1'b1);
        test_random_traffic(500, '1, 1'b1);
        test_random_traffic(350, CFG_W'(16), 1'b1);
        test_random_traffic(500, CFG_W'($urandom_range(0, 31)), 1'b0);

        // drain
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
        if (fail_count == 0)
            $display("pow2_free_list_allocator_top_tb: clean");
        else
            $display("pow2_free_list_allocator_top_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/p2fl_pkg.sv
rtl/p2fl_ram.sv
rtl/p2fl_seq.sv
rtl/p2fl_dp.sv
rtl/pow2_free_list_allocator_top.sv
test/pow2_free_list_allocator_top_tb.sv
